@@ hw/rtl/lab_pkg.sv @@
`timescale 1ns / 1ps
// lab_pkg: types, constants and step functions for the look-at basis builder.
// Used by look_at_basis_builder and its test bench; depends on nothing.
package lab_pkg;

	localparam int UNIT_BITS       = 30;
	localparam int ROOT_STEPS      = 32;
	localparam int QUO_STEPS       = 31;
	localparam int STEPS_PER_STAGE = 2;
	localparam int NUM_MAG         = 5;

	// integer square root state: remaining radicand and partial root
	typedef struct packed {
		logic [63:0] x;
		logic [63:0] r;
	} root_t;

	// restoring division state
	typedef struct packed {
		logic [31:0] rem;
		logic [30:0] nlo;
		logic [30:0] q;
	} quo_t;

	typedef struct packed {
		logic        neg_x;
		logic        neg_y;
		logic        neg_z;
		logic        zero_look;
		logic        zero_horiz;
		logic [30:0] sc_right;
		logic [30:0] sc_up;
		logic [30:0] sc_look;
	} side_t;

	function automatic logic [63:0] root_bit(int j);
		return 64'd1 << (62 - 2 * j);
	endfunction

	function automatic root_t root_step(root_t s, logic [63:0] b);
		root_t o;
		logic [63:0] t;
		t = s.r + b;
		o = s;
		if (s.x >= t) begin
			o.x = s.x - t;
			o.r = (s.r >> 1) + b;
		end else begin
			o.r = s.r >> 1;
		end
		return o;
	endfunction

	function automatic logic [4:0] msb_pos(logic [31:0] m);
		logic [4:0] p;
		p = '0;
		for (int i = 0; i < 32; i++) begin
			if (m[i]) p = 5'(i);
		end
		return p;
	endfunction

	// bring a magnitude to the range where the largest one sits in [2^30, 2^31)
	function automatic logic [30:0] norm_mag(logic [31:0] mag, logic [4:0] p);
		logic [62:0] w;
		w = {31'd0, mag} << (5'd30 - p);
		if (p == 5'd31) return mag[31:1];
		return w[30:0];
	endfunction

	// numerator (mag << 30) + len/2, split into starting remainder and low bits
	function automatic quo_t quo_init(logic [30:0] mag, logic [31:0] len);
		quo_t o;
		logic [61:0] n;
		n = {1'b0, mag, 30'd0} + {31'd0, len[31:1]};
		o.rem = {1'b0, n[61:31]};
		o.nlo = n[30:0];
		o.q   = '0;
		return o;
	endfunction

	function automatic quo_t quo_step(quo_t d, logic [31:0] len);
		quo_t o;
		logic [32:0] t;
		t = {d.rem, d.nlo[30]};
		o.nlo = {d.nlo[29:0], 1'b0};
		if (t >= {1'b0, len}) begin
			o.rem = 32'(t - {1'b0, len});
			o.q   = {d.q[29:0], 1'b1};
		end else begin
			o.rem = t[31:0];
			o.q   = {d.q[29:0], 1'b0};
		end
		return o;
	endfunction

	function automatic logic [61:0] mul31(logic [30:0] a, logic [30:0] b);
		logic [61:0] p;
		p = {31'd0, a} * {31'd0, b};
		return p;
	endfunction

	// product / 2^30, ties away from zero (on magnitudes)
	function automatic logic [30:0] round_unit(logic [61:0] p);
		logic [61:0] s;
		s = p + (62'd1 << (UNIT_BITS - 1));
		return s[60:30];
	endfunction

	function automatic logic [31:0] apply_sign(logic [30:0] m, logic neg);
		logic [31:0] w;
		w = {1'b0, m};
		return neg ? 32'(-w) : w;
	endfunction

endpackage

@@ hw/rtl/look_at_basis_builder.sv @@
`timescale 1ns / 1ps
// look_at_basis_builder: scaled right/up/look rows of a left-handed look-at basis.
// Pipelined; throughput one transaction per cycle unless out_ready stalls the output.
// Depth is set by two 32-step square roots and a 31-step divider, two steps per stage.
// Each stage loads whenever it is empty or its successor loads, so bubbles fill under stall.
// Reset (arst_n, async) clears only the stage valid bits; datapath registers are not reset.
module look_at_basis_builder (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic signed [31:0] position_x,
	input  logic signed [31:0] position_y,
	input  logic signed [31:0] position_z,
	input  logic signed [31:0] target_x,
	input  logic signed [31:0] target_y,
	input  logic signed [31:0] target_z,
	input  logic        [30:0] scale_right,
	input  logic        [30:0] scale_up,
	input  logic        [30:0] scale_look,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [31:0] right_x,
	output logic signed [31:0] right_y,
	output logic signed [31:0] right_z,
	output logic signed [31:0] up_x,
	output logic signed [31:0] up_y,
	output logic signed [31:0] up_z,
	output logic signed [31:0] look_x,
	output logic signed [31:0] look_y,
	output logic signed [31:0] look_z,
	output logic               degenerate
);
	import lab_pkg::*;

	localparam int ROOT_STAGES = (ROOT_STEPS + STEPS_PER_STAGE - 1) / STEPS_PER_STAGE;
	localparam int QUO_STAGES  = (QUO_STEPS + STEPS_PER_STAGE - 1) / STEPS_PER_STAGE;
	localparam int S_DIF = 0;
	localparam int S_ABS = 1;
	localparam int S_NRM = 2;
	localparam int S_SQR = 3;
	localparam int S_SUM = 4;
	localparam int S_RT1 = 5;
	localparam int S_DVP = S_RT1 + ROOT_STAGES;
	localparam int S_DIV = S_DVP + 1;
	localparam int S_UPM = S_DIV + QUO_STAGES;
	localparam int S_UPS = S_UPM + 1;
	localparam int S_RT2 = S_UPS + 1;
	localparam int S_SCM = S_RT2 + ROOT_STAGES;
	localparam int S_OUT = S_SCM + 1;
	localparam int NST   = S_OUT + 1;

	logic [NST-1:0] v_q;
	logic [NST-1:0] en;

	always_comb begin
		en[NST-1] = ~v_q[NST-1] | out_ready;
		for (int k = NST - 2; k >= 0; k--) begin
			en[k] = ~v_q[k] | en[k+1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
		end else begin
			if (en[0]) v_q[0] <= in_valid;
			for (int k = 1; k < NST; k++) begin
				if (en[k]) v_q[k] <= v_q[k-1];
			end
		end
	end

	assign in_ready  = en[0];
	assign out_valid = v_q[NST-1];

	// ---------------------------------------------------------------- side band
	side_t side_s [S_DIF:S_SCM];

	// ---------------------------------------------------------------- stage 0: differences
	logic signed [32:0] lx_s0, ly_s0, lz_s0;
	logic signed [32:0] dx, dy, dz;

	assign dx = {target_x[31], target_x} - {position_x[31], position_x};
	assign dy = {target_y[31], target_y} - {position_y[31], position_y};
	assign dz = {target_z[31], target_z} - {position_z[31], position_z};

	always_ff @(posedge clk) begin
		if (en[S_DIF]) begin
			lx_s0 <= dx;
			ly_s0 <= dy;
			lz_s0 <= dz;
			side_s[S_DIF] <= '{neg_x: dx[32], neg_y: dy[32], neg_z: dz[32],
				zero_look: 1'b0, zero_horiz: 1'b0,
				sc_right: scale_right, sc_up: scale_up, sc_look: scale_look};
		end
	end

	// ---------------------------------------------------------------- stage 1: magnitudes
	logic [31:0] mx_s1, my_s1, mz_s1, maxl_s1, maxh_s1;
	logic [32:0] ax, ay, az;
	logic [31:0] mxz;

	assign ax  = lx_s0[32] ? -lx_s0 : lx_s0;
	assign ay  = ly_s0[32] ? -ly_s0 : ly_s0;
	assign az  = lz_s0[32] ? -lz_s0 : lz_s0;
	assign mxz = (ax[31:0] > az[31:0]) ? ax[31:0] : az[31:0];

	always_ff @(posedge clk) begin
		if (en[S_ABS]) begin
			mx_s1   <= ax[31:0];
			my_s1   <= ay[31:0];
			mz_s1   <= az[31:0];
			maxh_s1 <= mxz;
			maxl_s1 <= (ay[31:0] > mxz) ? ay[31:0] : mxz;
		end
	end

	// ---------------------------------------------------------------- stage 2: normalize
	// entries 0..2 look x/y/z, 3..4 horizontal x/z
	logic [NUM_MAG-1:0][30:0] nm_s [S_NRM:S_DVP-1];
	logic [4:0] pl, ph;

	assign pl = msb_pos(maxl_s1);
	assign ph = msb_pos(maxh_s1);

	always_ff @(posedge clk) begin
		if (en[S_NRM]) begin
			nm_s[S_NRM][0] <= norm_mag(mx_s1, pl);
			nm_s[S_NRM][1] <= norm_mag(my_s1, pl);
			nm_s[S_NRM][2] <= norm_mag(mz_s1, pl);
			nm_s[S_NRM][3] <= norm_mag(mx_s1, ph);
			nm_s[S_NRM][4] <= norm_mag(mz_s1, ph);
		end
	end

	for (genvar k = S_NRM + 1; k < S_DVP; k++) begin : g_nm
		always_ff @(posedge clk) begin
			if (en[k]) nm_s[k] <= nm_s[k-1];
		end
	end

	for (genvar k = S_DIF + 1; k <= S_SCM; k++) begin : g_side
		if (k == S_NRM) begin : g_zero
			side_t nxt;
			always_comb begin
				nxt            = side_s[k-1];
				nxt.zero_look  = (maxl_s1 == 32'd0);
				nxt.zero_horiz = (maxh_s1 == 32'd0);
			end
			always_ff @(posedge clk) begin
				if (en[k]) side_s[k] <= nxt;
			end
		end else begin : g_pass
			always_ff @(posedge clk) begin
				if (en[k]) side_s[k] <= side_s[k-1];
			end
		end
	end

	// ---------------------------------------------------------------- stage 3/4: sum of squares
	logic [NUM_MAG-1:0][61:0] sq_s3;
	logic [63:0] suml_s4, sumh_s4;

	always_ff @(posedge clk) begin
		if (en[S_SQR]) begin
			for (int i = 0; i < NUM_MAG; i++) begin
				sq_s3[i] <= mul31(nm_s[S_NRM][i], nm_s[S_NRM][i]);
			end
		end
		if (en[S_SUM]) begin
			suml_s4 <= {2'b0, sq_s3[0]} + {2'b0, sq_s3[1]} + {2'b0, sq_s3[2]};
			sumh_s4 <= {2'b0, sq_s3[3]} + {2'b0, sq_s3[4]};
		end
	end

	// ---------------------------------------------------------------- vector lengths
	root_t rl_s [S_RT1:S_DVP-1];
	root_t rh_s [S_RT1:S_DVP-1];

	for (genvar g = 0; g < ROOT_STAGES; g++) begin : g_rt1
		root_t il, ih, ol, oh;
		if (g == 0) begin : g_first
			assign il = '{x: suml_s4, r: 64'd0};
			assign ih = '{x: sumh_s4, r: 64'd0};
		end else begin : g_next
			assign il = rl_s[S_RT1+g-1];
			assign ih = rh_s[S_RT1+g-1];
		end
		always_comb begin
			ol = il;
			oh = ih;
			for (int t = 0; t < STEPS_PER_STAGE; t++) begin
				if (g * STEPS_PER_STAGE + t < ROOT_STEPS) begin
					ol = root_step(ol, root_bit(g * STEPS_PER_STAGE + t));
					oh = root_step(oh, root_bit(g * STEPS_PER_STAGE + t));
				end
			end
		end
		always_ff @(posedge clk) begin
			if (en[S_RT1+g]) begin
				rl_s[S_RT1+g] <= ol;
				rh_s[S_RT1+g] <= oh;
			end
		end
	end

	// ---------------------------------------------------------------- unit components
	quo_t             qd_s  [S_DVP:S_UPM-1][NUM_MAG];
	logic [1:0][31:0] len_s [S_DVP:S_UPM-1];

	always_ff @(posedge clk) begin
		if (en[S_DVP]) begin
			len_s[S_DVP][0] <= rl_s[S_DVP-1].r[31:0];
			len_s[S_DVP][1] <= rh_s[S_DVP-1].r[31:0];
			for (int i = 0; i < NUM_MAG; i++) begin
				qd_s[S_DVP][i] <= quo_init(nm_s[S_DVP-1][i],
					(i < 3) ? rl_s[S_DVP-1].r[31:0] : rh_s[S_DVP-1].r[31:0]);
			end
		end
	end

	for (genvar g = 0; g < QUO_STAGES; g++) begin : g_div
		quo_t od [NUM_MAG];
		always_comb begin
			for (int i = 0; i < NUM_MAG; i++) begin
				od[i] = qd_s[S_DIV+g-1][i];
				for (int t = 0; t < STEPS_PER_STAGE; t++) begin
					if (g * STEPS_PER_STAGE + t < QUO_STEPS) begin
						od[i] = quo_step(od[i],
							(i < 3) ? len_s[S_DIV+g-1][0] : len_s[S_DIV+g-1][1]);
					end
				end
			end
		end
		always_ff @(posedge clk) begin
			if (en[S_DIV+g]) begin
				len_s[S_DIV+g] <= len_s[S_DIV+g-1];
				for (int i = 0; i < NUM_MAG; i++) begin
					qd_s[S_DIV+g][i] <= od[i];
				end
			end
		end
	end

	// ---------------------------------------------------------------- up vector
	logic [NUM_MAG-1:0][30:0] um;
	logic [NUM_MAG-1:0][30:0] um_s   [S_UPM:S_SCM-1];
	logic [3:0][61:0]         pp_s38;
	logic [61:0]              sum2_s39;
	logic [1:0][30:0]         upxz_s [S_UPS:S_SCM-1];

	always_comb begin
		for (int i = 0; i < NUM_MAG; i++) begin
			if (i < 3) um[i] = side_s[S_UPM-1].zero_look ? 31'd0 : qd_s[S_UPM-1][i].q;
			else       um[i] = side_s[S_UPM-1].zero_horiz ? 31'd0 : qd_s[S_UPM-1][i].q;
		end
	end

	always_ff @(posedge clk) begin
		if (en[S_UPM]) begin
			um_s[S_UPM] <= um;
			pp_s38[0]   <= mul31(um[0], um[0]);
			pp_s38[1]   <= mul31(um[2], um[2]);
			pp_s38[2]   <= mul31(um[1], um[3]);
			pp_s38[3]   <= mul31(um[1], um[4]);
		end
		if (en[S_UPS]) begin
			sum2_s39          <= pp_s38[0] + pp_s38[1];
			upxz_s[S_UPS][0]  <= round_unit(pp_s38[2]);
			upxz_s[S_UPS][1]  <= round_unit(pp_s38[3]);
		end
	end

	for (genvar k = S_UPM + 1; k < S_SCM; k++) begin : g_um
		always_ff @(posedge clk) begin
			if (en[k]) um_s[k] <= um_s[k-1];
		end
	end

	for (genvar k = S_UPS + 1; k < S_SCM; k++) begin : g_upxz
		always_ff @(posedge clk) begin
			if (en[k]) upxz_s[k] <= upxz_s[k-1];
		end
	end

	root_t r2_s [S_RT2:S_SCM-1];

	for (genvar g = 0; g < ROOT_STAGES; g++) begin : g_rt2
		root_t ir, orr;
		if (g == 0) begin : g_first
			assign ir = '{x: {2'b0, sum2_s39}, r: 64'd0};
		end else begin : g_next
			assign ir = r2_s[S_RT2+g-1];
		end
		always_comb begin
			orr = ir;
			for (int t = 0; t < STEPS_PER_STAGE; t++) begin
				if (g * STEPS_PER_STAGE + t < ROOT_STEPS) begin
					orr = root_step(orr, root_bit(g * STEPS_PER_STAGE + t));
				end
			end
		end
		always_ff @(posedge clk) begin
			if (en[S_RT2+g]) r2_s[S_RT2+g] <= orr;
		end
	end

	// ---------------------------------------------------------------- scaling and output
	logic [7:0][61:0] prod_s56;
	logic [30:0]      upy;
	side_t            sd;

	assign upy = side_s[S_SCM-1].zero_horiz ? 31'd0 : r2_s[S_SCM-1].r[30:0];
	assign sd  = side_s[S_SCM];

	always_ff @(posedge clk) begin
		if (en[S_SCM]) begin
			prod_s56[0] <= mul31(um_s[S_SCM-1][4], side_s[S_SCM-1].sc_right);
			prod_s56[1] <= mul31(um_s[S_SCM-1][3], side_s[S_SCM-1].sc_right);
			prod_s56[2] <= mul31(upxz_s[S_SCM-1][0], side_s[S_SCM-1].sc_up);
			prod_s56[3] <= mul31(upy, side_s[S_SCM-1].sc_up);
			prod_s56[4] <= mul31(upxz_s[S_SCM-1][1], side_s[S_SCM-1].sc_up);
			prod_s56[5] <= mul31(um_s[S_SCM-1][0], side_s[S_SCM-1].sc_look);
			prod_s56[6] <= mul31(um_s[S_SCM-1][1], side_s[S_SCM-1].sc_look);
			prod_s56[7] <= mul31(um_s[S_SCM-1][2], side_s[S_SCM-1].sc_look);
		end
	end

	// right = (cz, 0, -cx), up = (-uy*cx, p, -uy*cz)
	logic [31:0] rx_s57, rz_s57, ux_s57, uy_s57, uz_s57, lkx_s57, lky_s57, lkz_s57;
	logic        dg_s57;

	always_ff @(posedge clk) begin
		if (en[S_OUT]) begin
			rx_s57  <= apply_sign(round_unit(prod_s56[0]), sd.neg_z);
			rz_s57  <= apply_sign(round_unit(prod_s56[1]), ~sd.neg_x);
			ux_s57  <= apply_sign(round_unit(prod_s56[2]), ~(sd.neg_y ^ sd.neg_x));
			uy_s57  <= apply_sign(round_unit(prod_s56[3]), 1'b0);
			uz_s57  <= apply_sign(round_unit(prod_s56[4]), ~(sd.neg_y ^ sd.neg_z));
			lkx_s57 <= apply_sign(round_unit(prod_s56[5]), sd.neg_x);
			lky_s57 <= apply_sign(round_unit(prod_s56[6]), sd.neg_y);
			lkz_s57 <= apply_sign(round_unit(prod_s56[7]), sd.neg_z);
			dg_s57  <= sd.zero_look | sd.zero_horiz;
		end
	end

	assign right_x    = rx_s57;
	assign right_y    = 32'sd0;
	assign right_z    = rz_s57;
	assign up_x       = ux_s57;
	assign up_y       = uy_s57;
	assign up_z       = uz_s57;
	assign look_x     = lkx_s57;
	assign look_y     = lky_s57;
	assign look_z     = lkz_s57;
	assign degenerate = dg_s57;

endmodule

@@ sim/look_at_basis_builder_test.sv @@
`timescale 1ns / 1ps
// look_at_basis_builder_test: self-checking bench for the look-at basis builder.
// Depends on lab_pkg and look_at_basis_builder; a directed table, then random traffic.
module look_at_basis_builder_test;
	import lab_pkg::*;

	typedef struct {
		logic signed [31:0] px, py, pz, tx, ty, tz;
		logic        [30:0] sr, su, sl;
	} obj_t;

	typedef struct {
		logic signed [31:0] rx, ry, rz, ux, uy, uz, lx, ly, lz;
		logic               degen;
	} basis_t;

	typedef struct {
		obj_t   obj;
		bit     typed;
		basis_t res;
	} row_t;

	logic               clk, arst_n;
	logic               in_valid, in_ready, out_valid, out_ready;
	logic signed [31:0] position_x, position_y, position_z;
	logic signed [31:0] target_x, target_y, target_z;
	logic        [30:0] scale_right, scale_up, scale_look;
	logic signed [31:0] right_x, right_y, right_z, up_x, up_y, up_z;
	logic signed [31:0] look_x, look_y, look_z;
	logic               degenerate;

	basis_t pending_basis[$];
	row_t   dir_tab[$];
	int     fail_cnt, idle_cnt, quiet, n_acc, n_res, n_degen;
	bit     sending_done;

	look_at_basis_builder dut (.*);

	always begin
		clk = 1'b0; #5;
		clk = 1'b1; #5;
	end

	function automatic longint unsigned int_sqrt(longint unsigned x);
		longint unsigned r, b;
		r = 0;
		b = 64'd1 << 62;
		while (b > x) b >>= 2;
		while (b != 0) begin
			if (x >= r + b) begin
				x -= r + b;
				r = (r >> 1) + b;
			end else begin
				r >>= 1;
			end
			b >>= 2;
		end
		return r;
	endfunction

	// unit vector in Q2.30; returns 0 for a zero-length vector
	function automatic bit unit_vec(input longint c[3], input int n, output longint u[3]);
		longint unsigned mag[3], m, sum, len, q;
		m = 0;
		sum = 0;
		for (int i = 0; i < 3; i++) begin
			u[i] = 0;
			mag[i] = 0;
		end
		for (int i = 0; i < n; i++) begin
			mag[i] = c[i] < 0 ? longint'(-c[i]) : c[i];
			if (mag[i] > m) m = mag[i];
		end
		if (m == 0) return 1'b0;
		while (m >= (64'd1 << 31)) begin
			m >>= 1;
			for (int i = 0; i < n; i++) mag[i] >>= 1;
		end
		while (m < (64'd1 << 30)) begin
			m <<= 1;
			for (int i = 0; i < n; i++) mag[i] <<= 1;
		end
		for (int i = 0; i < n; i++) sum += mag[i] * mag[i];
		len = int_sqrt(sum);
		for (int i = 0; i < n; i++) begin
			q = ((mag[i] << UNIT_BITS) + (len >> 1)) / len;
			u[i] = c[i] < 0 ? -longint'(q) : longint'(q);
		end
		return 1'b1;
	endfunction

	function automatic longint scale_round(longint a, longint b);
		longint unsigned ma, mb, p;
		ma = a < 0 ? -a : a;
		mb = b < 0 ? -b : b;
		p = (ma * mb + (64'd1 << (UNIT_BITS - 1))) >> UNIT_BITS;
		return ((a < 0) != (b < 0)) ? -longint'(p) : longint'(p);
	endfunction

	function automatic logic signed [31:0] sat32(longint v);
		if (v > 64'sd2147483647) v = 64'sd2147483647;
		if (v < -64'sd2147483648) v = -64'sd2147483648;
		return v[31:0];
	endfunction

	function automatic basis_t predict_basis(obj_t o);
		longint lk[3], hz[3], ul[3], uh[3], ur[3], uu[3];
		bit ok_l, ok_h;
		basis_t b;
		lk[0] = longint'(o.tx) - longint'(o.px);
		lk[1] = longint'(o.ty) - longint'(o.py);
		lk[2] = longint'(o.tz) - longint'(o.pz);
		hz[0] = lk[0];
		hz[1] = lk[2];
		hz[2] = 0;
		ok_l = unit_vec(lk, 3, ul);
		ok_h = unit_vec(hz, 2, uh);
		ur[0] = uh[1];
		ur[1] = 0;
		ur[2] = -uh[0];
		uu[0] = -scale_round(ul[1], uh[0]);
		uu[1] = ok_h ? longint'(int_sqrt(ul[0] * ul[0] + ul[2] * ul[2])) : 0;
		uu[2] = -scale_round(ul[1], uh[1]);
		b.rx = sat32(scale_round(ur[0], o.sr));
		b.ry = sat32(scale_round(ur[1], o.sr));
		b.rz = sat32(scale_round(ur[2], o.sr));
		b.ux = sat32(scale_round(uu[0], o.su));
		b.uy = sat32(scale_round(uu[1], o.su));
		b.uz = sat32(scale_round(uu[2], o.su));
		b.lx = sat32(scale_round(ul[0], o.sl));
		b.ly = sat32(scale_round(ul[1], o.sl));
		b.lz = sat32(scale_round(ul[2], o.sl));
		b.degen = !(ok_l && ok_h);
		return b;
	endfunction

	function automatic basis_t basis_of(int rx, int ry, int rz, int ux, int uy, int uz,
			int lx, int ly, int lz, bit d);
		basis_t b;
		b.rx = rx; b.ry = ry; b.rz = rz;
		b.ux = ux; b.uy = uy; b.uz = uz;
		b.lx = lx; b.ly = ly; b.lz = lz;
		b.degen = d;
		return b;
	endfunction

	task automatic add_row(int px, int py, int pz, int tx, int ty, int tz,
			int sr, int su, int sl, bit typed, basis_t res);
		row_t r;
		r.obj = '{px, py, pz, tx, ty, tz, sr[30:0], su[30:0], sl[30:0]};
		r.typed = typed;
		r.res = res;
		dir_tab.push_back(r);
	endtask

	function automatic logic signed [31:0] rand_coord(int mode, logic signed [31:0] near);
		case (mode)
			0: return $urandom;
			1: return $signed($urandom_range(0, 32'h0020_0000)) - 32'sh0010_0000;
			default: return near + $signed($urandom_range(0, 64)) - 32;
		endcase
	endfunction

	function automatic logic [30:0] rand_scale();
		case ($urandom_range(0, 9))
			0: return '0;
			1: return 31'h7fff_ffff;
			2: return 31'h0001_0000;
			3, 4: return 31'($urandom_range(0, 32'h0010_0000));
			default: return 31'($urandom);
		endcase
	endfunction

	function automatic obj_t rand_obj();
		obj_t o;
		int mode;
		mode = $urandom_range(0, 2);
		o.px = rand_coord(mode == 2 ? 0 : mode, 0);
		o.py = rand_coord(mode == 2 ? 0 : mode, 0);
		o.pz = rand_coord(mode == 2 ? 0 : mode, 0);
		o.tx = rand_coord(mode, o.px);
		o.ty = rand_coord(mode, o.py);
		o.tz = rand_coord(mode, o.pz);
		case ($urandom_range(0, 19))
			0: begin o.tx = o.px; o.ty = o.py; o.tz = o.pz; end
			1: begin o.tx = o.px; o.tz = o.pz; end
			2: o.tx = o.px;
			3: o.tz = o.pz;
			default: ;
		endcase
		o.sr = rand_scale();
		o.su = rand_scale();
		o.sl = rand_scale();
		return o;
	endfunction

	task automatic drive_obj(obj_t o);
		position_x <= o.px; position_y <= o.py; position_z <= o.pz;
		target_x   <= o.tx; target_y   <= o.ty; target_z   <= o.tz;
		scale_right <= o.sr; scale_up <= o.su; scale_look <= o.sl;
		in_valid <= 1'b1;
		do @(posedge clk); while (!in_ready);
	endtask

	// gap before the next transaction; valid drops only if a gap is taken
	task automatic maybe_gap();
		if (!quiet && $urandom_range(0, 99) < 35) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
	endtask

	// sender
	initial begin
		obj_t o;
		basis_t z;
		z = basis_of(0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
		in_valid = 0; out_ready = 0;
		position_x = 0; position_y = 0; position_z = 0;
		target_x = 0; target_y = 0; target_z = 0;
		scale_right = 0; scale_up = 0; scale_look = 0;
		quiet = 0;
		sending_done = 0;
		arst_n = 0;
		repeat (4) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// target at position: all zero, degenerate
		add_row(0, 0, 0, 0, 0, 0, 65536, 65536, 65536, 1, basis_of(0,0,0,0,0,0,0,0,0,1));
		add_row(32'h7fffffff, 32'h80000000, 5, 32'h7fffffff, 32'h80000000, 5,
			32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 1, basis_of(0,0,0,0,0,0,0,0,0,1));
		// straight above / below: only look survives
		add_row(0, 0, 0, 0, 65536, 0, 65536, 65536, 65536, 1,
			basis_of(0, 0, 0, 0, 0, 0, 0, 65536, 0, 1));
		add_row(0, 0, 0, 0, -65536, 0, 65536, 65536, 65536, 1,
			basis_of(0, 0, 0, 0, 0, 0, 0, -65536, 0, 1));
		add_row(0, 32'h7fffffff, 0, 0, 32'h80000000, 0, 0, 0, 131072, 1,
			basis_of(0, 0, 0, 0, 0, 0, 0, -131072, 0, 1));
		// axis-aligned looks
		add_row(0, 0, 0, 0, 0, 65536, 65536, 65536, 65536, 1,
			basis_of(65536, 0, 0, 0, 65536, 0, 0, 0, 65536, 0));
		add_row(0, 0, 0, 65536, 0, 0, 65536, 65536, 65536, 1,
			basis_of(0, 0, -65536, 0, 65536, 0, 65536, 0, 0, 0));
		// zero scales: zeros but not degenerate
		add_row(0, 0, 0, 65536, 0, 0, 0, 0, 0, 1, basis_of(0,0,0,0,0,0,0,0,0,0));
		// extremes and assorted small cases, predictor checked
		add_row(32'h80000000, 32'h80000000, 32'h80000000, 32'h7fffffff, 32'h7fffffff,
			32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 0, z);
		add_row(32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h80000000, 32'h80000000,
			32'h80000000, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 0, z);
		add_row(32'h7fffffff, 0, 32'h80000000, 32'h80000000, 0, 32'h7fffffff,
			32'h7fffffff, 1, 32'h7fffffff, 0, z);
		add_row(0, 0, 0, 1, 1, 1, 65536, 65536, 65536, 0, z);
		add_row(0, 0, 0, -1, 0, 0, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 0, z);
		add_row(0, 0, 0, 3 << 16, 4 << 16, 0, 65536, 65536, 65536, 0, z);
		add_row(100, -200, 300, -400, 500, -600, 1, 1, 1, 0, z);
		add_row(0, 0, 0, 32'h40000000, 32'h40000000, 32'h40000000, 32'h12345678,
			32'h55555555, 32'h2aaaaaaa, 0, z);

		foreach (dir_tab[i]) begin
			pending_basis.push_back(dir_tab[i].typed ? dir_tab[i].res
				: predict_basis(dir_tab[i].obj));
			drive_obj(dir_tab[i].obj);
			maybe_gap();
		end

		for (int i = 0; i < 1000; i++) begin
			quiet = (i >= 400 && i < 600);
			if (i == 700) begin
				// drain fully before resuming
				in_valid <= 1'b0;
				while (pending_basis.size() != 0) @(posedge clk);
			end
			o = rand_obj();
			pending_basis.push_back(predict_basis(o));
			drive_obj(o);
			maybe_gap();
		end
		in_valid <= 1'b0;
		quiet = 0;
		sending_done = 1;
	end

	always @(posedge clk) begin
		if (arst_n) out_ready <= quiet ? 1'b1 : ($urandom_range(0, 99) >= 35);
	end

	task automatic cmp(string nm, logic [31:0] e, logic [31:0] a);
		if (e !== a) begin
			fail_cnt++;
			if (fail_cnt <= 40)
				$display("%0t %s expected %h actual %h", $time, nm, e, a);
		end
	endtask

	// result checker
	always @(posedge clk) begin
		basis_t e;
		if (arst_n && in_valid && in_ready) n_acc++;
		if (arst_n && out_valid && out_ready) begin
			n_res++;
			if (pending_basis.size() == 0) begin
				fail_cnt++;
				$display("%0t unexpected result transaction", $time);
			end else begin
				e = pending_basis.pop_front();
				cmp("right_x", e.rx, right_x);
				cmp("right_y", e.ry, right_y);
				cmp("right_z", e.rz, right_z);
				cmp("up_x", e.ux, up_x);
				cmp("up_y", e.uy, up_y);
				cmp("up_z", e.uz, up_z);
				cmp("look_x", e.lx, look_x);
				cmp("look_y", e.ly, look_y);
				cmp("look_z", e.lz, look_z);
				cmp("degenerate", {31'd0, e.degen}, {31'd0, degenerate});
				if (e.degen) n_degen++;
			end
		end
	end

	// watchdog on cycles without any transaction
	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready)
				|| (sending_done && pending_basis.size() == 0))
			idle_cnt <= 0;
		else
			idle_cnt <= idle_cnt + 1;
		if (idle_cnt >= 5000) begin
			$display("watchdog expired with %0d results outstanding", pending_basis.size());
			$display("look_at_basis_builder: mismatch");
			$finish;
		end
	end

	initial begin
		fail_cnt = 0; idle_cnt = 0; n_acc = 0; n_res = 0; n_degen = 0;
		wait (sending_done);
		while (pending_basis.size() != 0) @(posedge clk);
		repeat (120) @(posedge clk);
		$display("%0d objects sent, %0d bases checked (%0d degenerate),", n_acc, n_res, n_degen);
		$display("directed extremes plus random traffic with stalls on both sides");
		if (fail_cnt == 0 && pending_basis.size() == 0)
			$display("look_at_basis_builder: match");
		else
			$display("look_at_basis_builder: mismatch");
		$finish;
	end

endmodule

@@ look_at_basis_builder.f @@
hw/rtl/lab_pkg.sv
hw/rtl/look_at_basis_builder.sv
sim/look_at_basis_builder_test.sv
